FILE: rtl/core/qrs_peak_detector_defines.svh
// Assertion macros for the QRS peak detector RTL.
`ifndef QRS_PEAK_DETECTOR_DEFINES_SVH
`define QRS_PEAK_DETECTOR_DEFINES_SVH

// Same-cycle implication, reset masked.
`define QRS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define QRS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/qrs_pd_pkg.sv
// Types, constants and helpers for the QRS peak detector.
package qrs_pd_pkg;

  localparam int SMP_W      = 16;
  localparam int LVL_W      = SMP_W + 4;
  localparam int PEAK_DEPTH = 32;
  localparam int PIDX_W     = $clog2(PEAK_DEPTH);
  localparam int RR_WINDOW  = 8;
  localparam int RIDX_W     = $clog2(RR_WINDOW);
  localparam int RSUM_W     = SMP_W + RIDX_W;
  localparam int CNT_W      = 32;
  localparam int RATE_W     = 12;
  localparam int MLIM_W     = 4;
  localparam int PULSE_W    = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;
  localparam int DIV_W      = 32;
  localparam int DVS_W      = 16;
  localparam int DCNT_W     = $clog2(DIV_W);

  // x/100 as (x * LIM_RECIP) >> LIM_SHIFT, exact for x below 2^24
  localparam int          LIM_SHIFT = 31;
  localparam logic [24:0] LIM_RECIP = 25'd21474837;

  localparam logic [RATE_W-1:0] RATE_RST = 12'd250;
  localparam logic [MLIM_W-1:0] MLIM_RST = 4'd5;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SAMPLE_RATE = 1'b0,
    CFG_MISS_LIMIT  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    DIV_PULSE,
    DIV_LIM0,
    DIV_LIM1,
    DIV_LIM2,
    DIV_TIME
  } div_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_ROUTE,
    S_PULSE,
    S_PULSE_W,
    S_CLASS,
    S_TH,
    S_LIM,
    S_LIM_W,
    S_SB_ADDR,
    S_SB_CHK,
    S_TIME,
    S_TIME_W,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    load;
    logic    eval;
    logic    classify;
    logic    th_upd;
    logic    sb_read;
    logic    sb_check;
    logic    pulse_max;
    logic    div_start;
    div_op_t div_op;
    logic    lim_mul;
    logic    lim_wr;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic peak;
    logic isr;
    logic rr_zero;
    logic regular;
    logic regular_r;
    logic need_sb;
    logic sb_hit;
    logic sb_last;
    logic div_done;
    logic div_busy;
    logic out_free;
  } sts_t;

  // RR limit percentages: low, high, miss.
  function automatic logic [7:0] lim_pct(input div_op_t op);
    logic [7:0] pct;
    unique case (op)
      DIV_LIM0: pct = 8'd92;
      DIV_LIM1: pct = 8'd116;
      DIV_LIM2: pct = 8'd166;
      default:  pct = 8'd0;
    endcase
    return pct;
  endfunction

  function automatic logic [SMP_W-1:0] sat16(input logic [DIV_W-1:0] v);
    return (|v[DIV_W-1:SMP_W]) ? {SMP_W{1'b1}} : v[SMP_W-1:0];
  endfunction

endpackage

FILE: rtl/core/qrs_pd_if.sv
// Sample and result channel interfaces.
interface qrs_pd_in_if import qrs_pd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface qrs_pd_out_if import qrs_pd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               r_peak;
  logic [SMP_W-1:0]   peak_value;
  logic [PULSE_W-1:0] pulse_bpm;
  logic [SMP_W-1:0]   time_seconds;
  logic               irregular;
  logic               searched_back;
  logic               miss_warning;

  modport source (output valid, output r_peak, output peak_value, output pulse_bpm,
                  output time_seconds, output irregular, output searched_back,
                  output miss_warning, input ready);
  modport sink   (input valid, input r_peak, input peak_value, input pulse_bpm,
                  input time_seconds, input irregular, input searched_back,
                  input miss_warning, output ready);
endinterface

FILE: rtl/core/qrs_peak_detector.sv
// Work per input transfer depends on its path: no peak, noise peak, irregular R peak or
// regular R peak (no pulse division at RR 0), plus a searchback that scans the peak ring
// until a hit or its last entry. Time and pulse use the 32-step shared divider, and each
// RR limit passes S_LIM and S_LIM_W; one sample is in work at a time, the next is taken
// once the result is in the output register. Reset (synchronous, rst_n low) clears all
// levels, counters and the RR ring, and marks every peak ring entry invalid.
module qrs_peak_detector import qrs_pd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  qrs_pd_in_if.sink             in_ch,
  qrs_pd_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t st;

  qrs_pd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  qrs_pd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_sample         (in_ch.sample),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_r_peak        (out_ch.r_peak),
    .out_peak_value    (out_ch.peak_value),
    .out_pulse_bpm     (out_ch.pulse_bpm),
    .out_time_seconds  (out_ch.time_seconds),
    .out_irregular     (out_ch.irregular),
    .out_searched_back (out_ch.searched_back),
    .out_miss_warning  (out_ch.miss_warning)
  );

endmodule

FILE: rtl/core/qrs_pd_div.sv
// Shared restoring divider, one quotient bit per cycle.
module qrs_pd_div import qrs_pd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + DCNT_W'(1);
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/qrs_pd_dp.sv
// Datapath: sample window, peak ring, levels, thresholds, RR statistics, outputs.
module qrs_pd_dp import qrs_pd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  st,
  input  logic [SMP_W-1:0]      in_sample,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_r_peak,
  output logic [SMP_W-1:0]      out_peak_value,
  output logic [PULSE_W-1:0]    out_pulse_bpm,
  output logic [SMP_W-1:0]      out_time_seconds,
  output logic                  out_irregular,
  output logic                  out_searched_back,
  output logic                  out_miss_warning
);

  // configuration
  logic [RATE_W-1:0] rate_r;
  logic [MLIM_W-1:0] mlim_r;
  logic [RATE_W-1:0] rate_eff;
  logic [MLIM_W-1:0] mlim_eff;

  // running state
  logic [SMP_W-1:0]  w0_r, w1_r, w2_r;
  logic [CNT_W-1:0]  sc_r, last_r_r;
  logic [PIDX_W-1:0] pidx_r;
  logic [LVL_W-1:0]  sig_r, noi_r, thh_r, thl_r;
  logic [SMP_W-1:0]  ok_ring_r [RR_WINDOW];
  logic [RIDX_W-1:0] ok_pos_r;
  logic [RSUM_W-1:0] ok_sum_r;
  logic [SMP_W-1:0]  lim_r [3];
  logic [MLIM_W-1:0] miss_r;
  logic [PULSE_W-1:0] pulse_r;
  logic [SMP_W-1:0]  time_r;

  // per-item scratch
  logic              peak_r, isr_r, regular_r, irr_r, sb_r;
  logic [SMP_W-1:0]  rr_r, pk_r, pval_r;
  logic [PIDX_W-1:0] sbk_r;
  div_op_t           op_r;
  logic [SMP_W+7:0]  lim_prod_r;

  // peak ring
  logic [SMP_W-1:0]  ring_mem [PEAK_DEPTH];
  logic [PEAK_DEPTH-1:0] ring_vld_r;
  logic [SMP_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [PIDX_W-1:0] rd_addr;

  // output register
  logic               ov_r, o_rp_r, o_irr_r, o_sb_r, o_warn_r;
  logic [SMP_W-1:0]   o_pv_r, o_time_r;
  logic [PULSE_W-1:0] o_pulse_r;

  // combinational
  logic               peak_c, isr_c, regular_c, need_sb_c, sb_hit_c, warn_c;
  logic [CNT_W-1:0]   rr_diff;
  logic [SMP_W-1:0]   rr_c, old_c, avg;
  logic [LVL_W+2:0]   sig7, noi7;
  logic [LVL_W+1:0]   sig3;
  logic [LVL_W-1:0]   sig_reg_nxt, sig_sb_nxt, noi_nxt, th_nxt;
  logic [LVL_W:0]     th_dn;
  logic [LVL_W-1:0]   sig_diff;
  logic [17:0]        pulse_num;
  logic [SMP_W+7:0]   lim_prod;
  logic [SMP_W+32:0]  lim_scaled;
  logic [SMP_W+1:0]   lim_q;
  logic [DIV_W-1:0]   div_dvd, div_q;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_busy, div_done;

  assign rate_eff = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign mlim_eff = (mlim_r == '0) ? MLIM_W'(1) : mlim_r;

  assign peak_c  = (sc_r >= CNT_W'(3)) && (w0_r < w1_r) && (w1_r > w2_r);
  assign isr_c   = peak_c && ({w1_r, 4'b0} > thh_r);
  assign rr_diff = sc_r - last_r_r;
  assign rr_c    = sat16(rr_diff);

  assign regular_c = (lim_r[0] < rr_r) && (rr_r < lim_r[1]);
  assign need_sb_c = rr_r > lim_r[2];

  assign rd_addr  = pidx_r - PIDX_W'(1) - sbk_r;
  assign old_c    = rd_vld_r ? rd_data_r : '0;
  assign sb_hit_c = {old_c, 4'b0} > thl_r;
  assign warn_c   = miss_r >= mlim_eff;

  // level updates: 2P + 7L/8 and 4P + 3S/4 in Q.4
  assign sig7 = ({3'b0, sig_r} << 3) - {3'b0, sig_r};
  assign noi7 = ({3'b0, noi_r} << 3) - {3'b0, noi_r};
  assign sig3 = ({2'b0, sig_r} << 1) + {2'b0, sig_r};
  assign sig_reg_nxt = LVL_W'({pk_r, 1'b0}) + sig7[LVL_W+2:3];
  assign noi_nxt     = LVL_W'({w1_r, 1'b0}) + noi7[LVL_W+2:3];
  assign sig_sb_nxt  = LVL_W'({old_c, 2'b0}) + sig3[LVL_W+1:2];

  // thresh_high = N + (S-N)/4, rounded down, so away from N when S < N
  assign sig_diff = (sig_r >= noi_r) ? (sig_r - noi_r) : (noi_r - sig_r);
  assign th_dn    = {1'b0, sig_diff} + (LVL_W+1)'(3);
  assign th_nxt   = (sig_r >= noi_r) ? (noi_r + (sig_diff >> 2))
                                     : (noi_r - th_dn[LVL_W:2]);

  assign avg        = ok_sum_r[RSUM_W-1:RIDX_W];
  assign lim_prod   = {8'b0, avg} * {16'b0, lim_pct(cmd.div_op)};
  // divide by 100 through the reciprocal, in the cycle after the product is registered
  assign lim_scaled = {25'b0, lim_prod_r} * {24'b0, LIM_RECIP};
  assign lim_q      = lim_scaled[SMP_W+32:LIM_SHIFT];
  assign pulse_num  = {6'b0, rate_eff} * 18'd60;

  always_comb begin
    unique case (cmd.div_op)
      DIV_PULSE: begin
        div_dvd = DIV_W'(pulse_num);
        div_dvs = rr_r;
      end
      DIV_TIME: begin
        div_dvd = sc_r;
        div_dvs = DVS_W'(rate_eff);
      end
      default: begin
        div_dvd = sc_r;
        div_dvs = DVS_W'(rate_eff);
      end
    endcase
  end

  qrs_pd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= RATE_RST;
      mlim_r     <= MLIM_RST;
      w0_r       <= '0;
      w1_r       <= '0;
      w2_r       <= '0;
      sc_r       <= '0;
      last_r_r   <= '0;
      pidx_r     <= '0;
      sig_r      <= '0;
      noi_r      <= '0;
      thh_r      <= '0;
      thl_r      <= '0;
      ok_pos_r   <= '0;
      ok_sum_r   <= '0;
      miss_r     <= '0;
      pulse_r    <= '0;
      time_r     <= '0;
      peak_r     <= 1'b0;
      isr_r      <= 1'b0;
      regular_r  <= 1'b0;
      irr_r      <= 1'b0;
      sb_r       <= 1'b0;
      ring_vld_r <= '0;
      ov_r       <= 1'b0;
      op_r       <= DIV_TIME;
      for (int i = 0; i < RR_WINDOW; i++) ok_ring_r[i] <= '0;
      for (int i = 0; i < 3; i++) lim_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SAMPLE_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_MISS_LIMIT:  mlim_r <= cfg_wdata[MLIM_W-1:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        if (sc_r != {CNT_W{1'b1}}) sc_r <= sc_r + CNT_W'(1);
        w0_r <= w1_r;
        w1_r <= w2_r;
        w2_r <= in_sample;
      end

      if (cmd.eval) begin
        peak_r    <= peak_c;
        isr_r     <= isr_c;
        regular_r <= 1'b0;
        irr_r     <= 1'b0;
        sb_r      <= 1'b0;
        if (peak_c) begin
          pidx_r             <= pidx_r + PIDX_W'(1);
          ring_vld_r[pidx_r] <= 1'b1;
        end
        if (isr_c) last_r_r <= sc_r;
        if (peak_c && !isr_c) noi_r <= noi_nxt;
      end

      if (cmd.pulse_max) pulse_r <= {PULSE_W{1'b1}};

      if (cmd.classify) begin
        regular_r <= regular_c;
        if (regular_c) begin
          ok_ring_r[ok_pos_r] <= rr_r;
          ok_sum_r <= ok_sum_r - RSUM_W'(ok_ring_r[ok_pos_r]) + RSUM_W'(rr_r);
          ok_pos_r <= ok_pos_r + RIDX_W'(1);
          sig_r    <= sig_reg_nxt;
          miss_r   <= '0;
        end else begin
          irr_r <= 1'b1;
          if (miss_r != {MLIM_W{1'b1}}) miss_r <= miss_r + MLIM_W'(1);
        end
      end

      if (cmd.sb_check && sb_hit_c) begin
        sig_r <= sig_sb_nxt;
        sb_r  <= 1'b1;
      end

      if (cmd.th_upd) begin
        thh_r <= th_nxt;
        thl_r <= th_nxt >> 1;
      end

      if (cmd.lim_wr) begin
        unique case (cmd.div_op)
          DIV_LIM0: lim_r[0] <= sat16(DIV_W'(lim_q));
          DIV_LIM1: lim_r[1] <= sat16(DIV_W'(lim_q));
          DIV_LIM2: lim_r[2] <= sat16(DIV_W'(lim_q));
          default: ;
        endcase
      end

      if (cmd.div_start) op_r <= cmd.div_op;
      if (div_done) begin
        unique case (op_r)
          DIV_PULSE: pulse_r  <= (|div_q[DIV_W-1:PULSE_W]) ? {PULSE_W{1'b1}}
                                                          : div_q[PULSE_W-1:0];
          DIV_TIME:  time_r   <= sat16(div_q);
          default: ;
        endcase
      end

      if (cmd.out_load) begin
        ov_r <= 1'b1;
        if (warn_c) miss_r <= '0;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end

      if (cmd.sb_read) rd_vld_r <= ring_vld_r[rd_addr];
    end

    // payload registers
    if (cmd.eval) begin
      pk_r   <= w1_r;
      rr_r   <= rr_c;
      pval_r <= peak_c ? w1_r : '0;
    end
    if (cmd.lim_mul) lim_prod_r <= lim_prod;
    if (cmd.classify) sbk_r <= PIDX_W'(1);
    else if (cmd.sb_check && !sb_hit_c) sbk_r <= sbk_r + PIDX_W'(1);
    if (cmd.out_load) begin
      o_rp_r    <= isr_r;
      o_pv_r    <= pval_r;
      o_pulse_r <= pulse_r;
      o_time_r  <= time_r;
      o_irr_r   <= irr_r;
      o_sb_r    <= sb_r;
      o_warn_r  <= warn_c;
    end
  end

  // peak ring storage
  always_ff @(posedge clk) begin
    if (cmd.eval && peak_c) ring_mem[pidx_r] <= w1_r;
    if (cmd.sb_read) rd_data_r <= ring_mem[rd_addr];
  end

  always_comb begin
    st.peak      = peak_r;
    st.isr       = isr_r;
    st.rr_zero   = rr_r == '0;
    st.regular   = regular_c;
    st.regular_r = regular_r;
    st.need_sb   = need_sb_c;
    st.sb_hit    = sb_hit_c;
    st.sb_last   = sbk_r == PIDX_W'(PEAK_DEPTH - 1);
    st.div_done  = div_done;
    st.div_busy  = div_busy;
    st.out_free  = !ov_r || out_ready;
  end

  assign out_valid         = ov_r;
  assign out_r_peak        = o_rp_r;
  assign out_peak_value    = o_pv_r;
  assign out_pulse_bpm     = o_pulse_r;
  assign out_time_seconds  = o_time_r;
  assign out_irregular     = o_irr_r;
  assign out_searched_back = o_sb_r;
  assign out_miss_warning  = o_warn_r;

endmodule

FILE: rtl/core/qrs_pd_ctrl.sv
// Controller: sequences one sample through classification, searchback and division.
`include "qrs_peak_detector_defines.svh"

module qrs_pd_ctrl import qrs_pd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t st,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] lim_sel_r, lim_sel_nxt;

  always_comb begin
    state_nxt   = state_r;
    lim_sel_nxt = lim_sel_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_EVAL;
      S_EVAL:    state_nxt = S_ROUTE;
      S_ROUTE: begin
        priority if (!st.peak) state_nxt = S_TIME;
        else if (!st.isr)      state_nxt = S_TH;
        else                   state_nxt = S_PULSE;
      end
      S_PULSE:   state_nxt = st.rr_zero ? S_CLASS : S_PULSE_W;
      S_PULSE_W: if (st.div_done) state_nxt = S_CLASS;
      S_CLASS: begin
        priority if (st.regular) state_nxt = S_TH;
        else if (st.need_sb)     state_nxt = S_SB_ADDR;
        else                     state_nxt = S_TIME;
      end
      S_TH: begin
        lim_sel_nxt = '0;
        state_nxt   = st.regular_r ? S_LIM : S_TIME;
      end
      S_LIM:     state_nxt = S_LIM_W;
      S_LIM_W: begin
        if (lim_sel_r == 2'd2) begin
          state_nxt = S_TIME;
        end else begin
          lim_sel_nxt = lim_sel_r + 2'd1;
          state_nxt   = S_LIM;
        end
      end
      S_SB_ADDR: state_nxt = S_SB_CHK;
      S_SB_CHK: begin
        priority if (st.sb_hit) state_nxt = S_TH;
        else if (st.sb_last)    state_nxt = S_TIME;
        else                    state_nxt = S_SB_ADDR;
      end
      S_TIME:    state_nxt = S_TIME_W;
      S_TIME_W:  if (st.div_done) state_nxt = S_FIN;
      S_FIN:     if (st.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.div_op = DIV_TIME;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EVAL:  cmd.eval = 1'b1;
      S_PULSE: begin
        cmd.div_op    = DIV_PULSE;
        cmd.pulse_max = st.rr_zero;
        cmd.div_start = !st.rr_zero;
      end
      S_CLASS:   cmd.classify = 1'b1;
      S_TH:      cmd.th_upd = 1'b1;
      // product registered in S_LIM, scaled limit written in S_LIM_W
      S_LIM, S_LIM_W: begin
        cmd.lim_mul = (state_r == S_LIM);
        cmd.lim_wr  = (state_r == S_LIM_W);
        unique case (lim_sel_r)
          2'd0:    cmd.div_op = DIV_LIM0;
          2'd1:    cmd.div_op = DIV_LIM1;
          default: cmd.div_op = DIV_LIM2;
        endcase
      end
      S_SB_ADDR: cmd.sb_read = 1'b1;
      S_SB_CHK:  cmd.sb_check = 1'b1;
      S_TIME:    cmd.div_start = 1'b1;
      S_FIN:     cmd.out_load = st.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lim_sel_r <= '0;
    end else begin
      state_r   <= state_nxt;
      lim_sel_r <= lim_sel_nxt;
    end
  end

  `QRS_ASSERT_NXT(a_accept_eval, in_valid && in_ready, state_r == S_EVAL, "transfer did not start evaluation")
  `QRS_ASSERT_IMP(a_div_start_idle, cmd.div_start, !st.div_busy, "divider started while busy")
  `QRS_ASSERT_IMP(a_lim_sel_range, state_r == S_LIM_W, lim_sel_r != 2'd3, "limit select out of range")
  `QRS_ASSERT_NXT(a_out_load_idle, cmd.out_load, state_r == S_IDLE, "result load did not return to idle")

endmodule
